@@ sv/ise_pkg.sv @@
// ----------------------------------------------------------------------------
// ise_pkg: shared types and constants of the integer sort engine
// Holds the store size, the data width, the control struct between the
// sequencer and the sorting cells, and the sequencer state encoding.
// ----------------------------------------------------------------------------
package ise_pkg;

  localparam int MaxItems = 64;
  localparam int DataBits = 32;

  typedef logic signed [DataBits-1:0] data_t;

  // commands broadcast to every cell of the chain
  typedef struct packed {
    logic ins;    // insert the broadcast value into place
    logic shift;  // move every entry one cell toward the head
  } ctrl_t;

  typedef enum logic [1:0] {
    StLoad  = 2'b01,
    StDrain = 2'b10
  } state_e;

endpackage

@@ sv/ise_if.sv @@
// ----------------------------------------------------------------------------
// ise_in_if / ise_out_if: valid-ready channels of the integer sort engine
// One interface for the incoming items and one for the sorted results.
// ----------------------------------------------------------------------------
interface ise_in_if
  import ise_pkg::*;
();
  logic  valid;
  logic  ready;
  data_t value;
  logic  last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface ise_out_if
  import ise_pkg::*;
();
  logic  valid;
  logic  ready;
  data_t value_res;
  logic  last_res;
  logic  overflow;

  modport source (output valid, output value_res, output last_res, output overflow,
                  input ready);
  modport sink   (input valid, input value_res, input last_res, input overflow,
                  output ready);
endinterface

@@ sv/ise_cell.sv @@
// ----------------------------------------------------------------------------
// ise_cell: one cell of the systolic insertion sorter
// Holds one entry and its occupied bit. On insert it keeps its entry, takes
// the entry of its upstream neighbor, or takes the new value; on shift it
// takes the entry of its downstream neighbor.
// ----------------------------------------------------------------------------
module ise_cell
  import ise_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  ctrl_t ctrl_i,
  input  data_t new_val_i,
  input  logic  prev_gt_i,
  input  data_t prev_val_i,
  input  logic  prev_occ_i,
  input  data_t next_val_i,
  input  logic  next_occ_i,
  output data_t val_o,
  output logic  occ_o,
  output logic  gt_o
);

  data_t val_q, val_d;
  logic  occ_q, occ_d;

  // an empty cell behaves as if it held plus infinity
  assign gt_o = !occ_q || (val_q > new_val_i);

  always_comb begin
    val_d = val_q;
    occ_d = occ_q;
    if (ctrl_i.ins) begin
      occ_d = occ_q | prev_occ_i;
      if (gt_o) begin
        val_d = prev_gt_i ? prev_val_i : new_val_i;
      end
    end else if (ctrl_i.shift) begin
      val_d = next_val_i;
      occ_d = next_occ_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;
  assign occ_o = occ_q;

endmodule

@@ sv/ise_ctrl.sv @@
// ----------------------------------------------------------------------------
// ise_ctrl: load / drain sequencer of the integer sort engine
// Accepts items while loading, drops them when the chain is full, and
// streams the chain out after the final item of a set.
// ----------------------------------------------------------------------------
module ise_ctrl
  import ise_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  in_last_i,
  input  logic  out_ready_i,
  input  logic  out_last_i,
  input  logic  full_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  output logic  overflow_o,
  output ctrl_t ctrl_o
);

  state_e state_q, state_d;
  logic   ovf_q, ovf_d;
  logic   in_fire, out_fire;

  assign in_ready_o  = (state_q == StLoad);
  assign out_valid_o = (state_q == StDrain);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_o && out_ready_i;

  assign ctrl_o.ins   = in_fire && !full_i;
  assign ctrl_o.shift = out_fire;

  always_comb begin
    state_d = state_q;
    ovf_d   = ovf_q;
    case (state_q)
      StLoad: begin
        if (in_fire) begin
          if (full_i) begin
            ovf_d = 1'b1;
          end
          if (in_last_i) begin
            state_d = StDrain;
          end
        end
      end
      StDrain: begin
        if (out_fire && out_last_i) begin
          state_d = StLoad;
          ovf_d   = 1'b0;
        end
      end
      default: begin
        state_d = StLoad;
        ovf_d   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ovf_q   <= ovf_d;
    end
  end

  assign overflow_o = ovf_q;

endmodule

@@ sv/integer_sort_engine.sv @@
// ----------------------------------------------------------------------------
// integer_sort_engine: ascending sort of a set of signed integers
// Loads a set one transaction per cycle into a chain of sorting cells and
// streams the set out in ascending order after its final item.
// ----------------------------------------------------------------------------
// throughput while loading: one item per cycle, each placed by a broadcast
//   compare in every cell of the chain
// drain: first result is valid the cycle after the final item is accepted,
//   then one result per cycle while the receiver is ready
// the next set is accepted the cycle after the final result is taken
// reset clears all cell occupied bits and the sequencer at once, no sweep
module integer_sort_engine
  import ise_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  ise_in_if.sink     in_i,
  ise_out_if.source  out_o
);

  ctrl_t ctrl;
  data_t cell_val [MaxItems];
  logic  cell_occ [MaxItems];
  logic  cell_gt  [MaxItems];
  logic  out_last;

  assign out_last = !cell_occ[1];

  ise_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_last_i   (in_i.last),
    .out_ready_i (out_o.ready),
    .out_last_i  (out_last),
    .full_i      (cell_occ[MaxItems-1]),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .overflow_o  (out_o.overflow),
    .ctrl_o      (ctrl)
  );

  for (genvar i = 0; i < MaxItems; i++) begin : g_cell
    logic  prev_gt, prev_occ, next_occ;
    data_t prev_val, next_val;

    if (i == 0) begin : g_head
      assign prev_gt  = 1'b0;
      assign prev_val = '0;
      assign prev_occ = 1'b1;
    end else begin : g_body
      assign prev_gt  = cell_gt[i-1];
      assign prev_val = cell_val[i-1];
      assign prev_occ = cell_occ[i-1];
    end

    if (i == MaxItems - 1) begin : g_tail
      assign next_val = '0;
      assign next_occ = 1'b0;
    end else begin : g_link
      assign next_val = cell_val[i+1];
      assign next_occ = cell_occ[i+1];
    end

    ise_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .new_val_i  (in_i.value),
      .prev_gt_i  (prev_gt),
      .prev_val_i (prev_val),
      .prev_occ_i (prev_occ),
      .next_val_i (next_val),
      .next_occ_i (next_occ),
      .val_o      (cell_val[i]),
      .occ_o      (cell_occ[i]),
      .gt_o       (cell_gt[i])
    );
  end

  assign out_o.value_res = cell_val[0];
  assign out_o.last_res  = out_last;

endmodule

@@ sv/ise_checker.sv @@
// ----------------------------------------------------------------------------
// ise_checker: port-level checks of the integer sort engine
// Watches both channels and checks the load / drain sequencing.
// ----------------------------------------------------------------------------
module ise_checker
  import ise_pkg::*;
(
  input logic  clk_i,
  input logic  rst_ni,
  input logic  in_valid_i,
  input logic  in_ready_i,
  input logic  in_last_i,
  input logic  out_valid_i,
  input logic  out_ready_i,
  input data_t out_value_i,
  input logic  out_last_i,
  input logic  out_overflow_i
);

  // no loading while a set is draining
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("input ready while results pending");

  // the final item of a set starts the drain
  a_drain_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && in_last_i) |=> out_valid_i)
    else $error("no result after final item");

  // the last result ends the drain
  a_drain_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && out_last_i) |=> (!out_valid_i && in_ready_i))
    else $error("drain did not end after last result");

  // overflow flag is the same on every result of a set
  a_ovf_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && !out_last_i) |=> (out_overflow_i == $past(out_overflow_i)))
    else $error("overflow flag changed within a set");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_value_i)))
    else $error("stalled result changed");

endmodule

bind integer_sort_engine ise_checker u_ise_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_last_i      (in_i.last),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_value_i    (out_o.value_res),
  .out_last_i     (out_o.last_res),
  .out_overflow_i (out_o.overflow)
);

@@ test/sort_order_monitor.sv @@
// ----------------------------------------------------------------------------
// sort_order_monitor: result predictor and scoreboard for the integer sort engine
// Watches both channels. Every accepted item is placed into a local sorted
// copy of the set. When the final item of a set arrives, the ascending results
// are queued. Each result taken from the block is compared field by field
// with the oldest queued result.
// ----------------------------------------------------------------------------
module sort_order_monitor
  import ise_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  in_ready_i,
  input  data_t in_value_i,
  input  logic  in_last_i,
  input  logic  out_valid_i,
  input  logic  out_ready_i,
  input  data_t out_value_i,
  input  logic  out_last_i,
  input  logic  out_overflow_i,
  output int    error_count_o,
  output int    pending_o,
  output int    results_o,
  output int    overflow_results_o
);

  typedef struct {
    data_t value;
    logic  last;
    logic  overflow;
  } sorted_result_t;

  sorted_result_t awaited_results[$];
  data_t          kept_vals[MaxItems];
  int             kept_count;
  logic           set_dropped;

  initial begin
    error_count_o      = 0;
    pending_o          = 0;
    results_o          = 0;
    overflow_results_o = 0;
    kept_count         = 0;
    set_dropped        = 1'b0;
  end

  // insertion into the ascending copy, equal values stay in arrival order
  task automatic place_item(data_t v);
    int pos;
    pos = kept_count;
    while (pos > 0 && kept_vals[pos-1] > v) begin
      kept_vals[pos] = kept_vals[pos-1];
      pos--;
    end
    kept_vals[pos] = v;
    kept_count++;
  endtask

  task automatic close_set();
    sorted_result_t r;
    for (int k = 0; k < kept_count; k++) begin
      r.value    = kept_vals[k];
      r.last     = (k == kept_count - 1);
      r.overflow = set_dropped;
      awaited_results.push_back(r);
    end
    kept_count  = 0;
    set_dropped = 1'b0;
  endtask

  task automatic check_result();
    sorted_result_t exp_r;
    if (awaited_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, got value_res %0d last_res %b overflow %b",
               $time, out_value_i, out_last_i, out_overflow_i);
      error_count_o++;
      return;
    end
    exp_r = awaited_results.pop_front();
    if (out_value_i !== exp_r.value) begin
      $display("%0t: value_res mismatch, expected %0d, got %0d",
               $time, exp_r.value, out_value_i);
      error_count_o++;
    end
    if (out_last_i !== exp_r.last) begin
      $display("%0t: last_res mismatch, expected %b, got %b", $time, exp_r.last, out_last_i);
      error_count_o++;
    end
    if (out_overflow_i !== exp_r.overflow) begin
      $display("%0t: overflow mismatch, expected %b, got %b",
               $time, exp_r.overflow, out_overflow_i);
      error_count_o++;
    end
    results_o++;
    if (exp_r.overflow) overflow_results_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_count  = 0;
      set_dropped = 1'b0;
      awaited_results.delete();
    end else begin
      if (out_valid_i && out_ready_i) check_result();
      if (in_valid_i && in_ready_i) begin
        // a full store drops the item, a final one still closes the set
        if (kept_count < MaxItems) place_item(in_value_i);
        else set_dropped = 1'b1;
        if (in_last_i) close_set();
      end
    end
    pending_o = awaited_results.size();
  end

endmodule

@@ test/integer_sort_engine_tb.sv @@
// ----------------------------------------------------------------------------
// integer_sort_engine_tb: top level of the integer sort engine testbench
// Sends directed sets (extremes, duplicates, reversed order) and then random
// sets, among them one that fills the store exactly and one that overflows
// it. The sender works in bursts and the receiver stalls on patterns, once for
// a long stretch. Checking is done by sort_order_monitor.
// ----------------------------------------------------------------------------
module integer_sort_engine_tb;
  import ise_pkg::*;

  localparam int    HoldCycles  = 300;
  localparam int    FullSet     = MaxItems;
  localparam int    OverSet     = MaxItems + 2;
  localparam int    TargetItems = 200;
  localparam data_t MaxVal      = {1'b0, {(DataBits-1){1'b1}}};
  localparam data_t MinVal      = {1'b1, {(DataBits-1){1'b0}}};

  logic clk;
  logic rst_n;

  ise_in_if  in_ch();
  ise_out_if out_ch();

  int    errors;
  int    pending;
  int    results;
  int    overflow_results;
  int    items_sent;
  int    sets_sent;
  int    burst_left;
  bit    hold_req;
  data_t set_vals[$];

  integer_sort_engine uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  sort_order_monitor order_mon (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_ch.valid),
    .in_ready_i         (in_ch.ready),
    .in_value_i         (in_ch.value),
    .in_last_i          (in_ch.last),
    .out_valid_i        (out_ch.valid),
    .out_ready_i        (out_ch.ready),
    .out_value_i        (out_ch.value_res),
    .out_last_i         (out_ch.last_res),
    .out_overflow_i     (out_ch.overflow),
    .error_count_o      (errors),
    .pending_o          (pending),
    .results_o          (results),
    .overflow_results_o (overflow_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results still awaited", pending);
    $display("== FAIL ==");
    $finish;
  end

  function automatic data_t pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return data_t'($urandom);
      5, 6, 7:       return data_t'(int'($urandom_range(0, 8)) - 4);
      8:             return $urandom_range(0, 1) ? MaxVal : MinVal;
      default:       return $urandom_range(0, 1) ? MaxVal - data_t'($urandom_range(0, 3))
                                                 : MinVal + data_t'($urandom_range(0, 3));
    endcase
  endfunction

  // one transaction; called and returns at a rising edge
  task automatic offer_item(data_t v, logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    in_ch.last  <= fin;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_set();
    for (int k = 0; k < set_vals.size(); k++) begin
      // the long receiver hold-off starts halfway through the full set
      if (set_vals.size() == FullSet && k == FullSet / 2) hold_req <= 1'b1;
      offer_item(set_vals[k], k == set_vals.size() - 1);
    end
    sets_sent++;
  endtask

  task automatic random_set(int n);
    set_vals.delete();
    for (int k = 0; k < n; k++) set_vals.push_back(pick_value());
    send_set();
  endtask

  // receiver: rotating stall patterns, and one long hold-off
  initial begin
    logic [15:0] pat;
    int          pat_age;
    bit          hold_done;
    pat       = 16'hFFFF;
    pat_age   = 0;
    hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        if (pat_age == 0) begin
          case ($urandom_range(0, 3))
            0:       pat = 16'hFFFF;
            1:       pat = 16'($urandom);
            2:       pat = ~(16'($urandom) & 16'($urandom));
            default: pat = 16'h0001;
          endcase
          if (pat == 16'h0000) pat = 16'h0001;
          pat_age = $urandom_range(16, 64);
        end
        out_ch.ready <= pat[0];
        pat = {pat[0], pat[15:1]};
        pat_age--;
      end
    end
  end

  initial begin
    int s;
    items_sent   = 0;
    sets_sent    = 0;
    burst_left   = 0;
    hold_req     = 1'b0;
    rst_n        = 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.value  <= '0;
    in_ch.last   <= 1'b0;
    out_ch.ready <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-item sets at both extremes
    set_vals = '{MaxVal};
    send_set();
    set_vals = '{MinVal};
    send_set();
    // mixed extremes with duplicates, final item in the middle of the range
    set_vals = '{data_t'(0), data_t'(-1), data_t'(1), MaxVal, MinVal,
                 data_t'(0), MaxVal, MinVal, data_t'(-1)};
    send_set();
    // all equal
    set_vals = '{data_t'(5), data_t'(5), data_t'(5), data_t'(5)};
    send_set();
    // strictly descending arrival
    set_vals = '{data_t'(7), data_t'(3), data_t'(-3), data_t'(-7)};
    send_set();

    // random sets; set 3 fills the store exactly, set 8 drops its final two items
    s = 0;
    while (items_sent < TargetItems || s <= 8) begin
      if (s == 3) random_set(FullSet);
      else if (s == 8) random_set(OverSet);
      else random_set($urandom_range(1, 8));
      s++;
    end
    in_ch.valid <= 1'b0;

    // let the monitor queue the final set before pending is polled
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("sent %0d items in %0d sets, incl. an exactly full and an overflowing set",
             items_sent, sets_sent);
    $display("checked %0d sorted results, %0d of them flagged overflow",
             results, overflow_results);
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/ise_pkg.sv
sv/ise_if.sv
sv/ise_cell.sv
sv/ise_ctrl.sv
sv/integer_sort_engine.sv
sv/ise_checker.sv
test/sort_order_monitor.sv
test/integer_sort_engine_tb.sv
